// File: rtl/mexp_pkg.sv
// Shared constants, types and command/status structs for the modular exponentiation unit.
`default_nettype none

package mexp_pkg;

  // Operand widths
  localparam int unsigned MOD_WIDTH = 31;
  localparam int unsigned EXP_WIDTH = 40;
  // Bit counter of the serial multiplier
  localparam int unsigned CNT_WIDTH = $clog2(MOD_WIDTH);
  // Modulus after reset
  localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(1000000007);

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_LD,
    ST_RED_RUN,
    ST_BIT_CHK,
    ST_ACC_LD,
    ST_ACC_RUN,
    ST_SQ_LD,
    ST_SQ_RUN,
    ST_DONE
  } state_e;

  // Operand selection for the serial multiplier
  typedef enum logic [1:0] {
    MUL_REDUCE,
    MUL_ACC,
    MUL_SQUARE
  } mul_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     mul_step;
    logic     wr_base;
    logic     wr_acc;
    logic     exp_shift;
    logic     finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mul_last;
    logic exp_zero;
    logic exp_bit;
    logic mod_zero;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/mexp_datapath.sv
// Datapath: modulus register, operand registers and bit-serial modular multiplier.
`default_nettype none

module mexp_datapath
  import mexp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [MOD_WIDTH-1:0] base_value_i,
  input  wire logic [EXP_WIDTH-1:0] exponent_value_i,
  input  wire logic                 modulus_we_i,
  input  wire logic [MOD_WIDTH-1:0] modulus_wdata_i,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  output logic [MOD_WIDTH-1:0]      power_result_o,
  output logic                      done_o
);

  logic [MOD_WIDTH-1:0] mod_q;
  logic [MOD_WIDTH-1:0] base_q, base_d;
  logic [MOD_WIDTH-1:0] acc_q, acc_d;
  logic [EXP_WIDTH-1:0] exp_q, exp_d;
  logic [MOD_WIDTH-1:0] mul_x_q, mul_x_d;
  logic [MOD_WIDTH-1:0] mul_y_q, mul_y_d;
  logic [MOD_WIDTH-1:0] mul_r_q, mul_r_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [MOD_WIDTH-1:0] res_q, res_d;
  logic                 done_q;
  logic [MOD_WIDTH-1:0] one_mod;
  logic [MOD_WIDTH:0]   dbl, dbl_red, sum;
  logic [MOD_WIDTH-1:0] step_r;
  logic [MOD_WIDTH:0]   mod_ext;

  // 1 mod m (m of zero is handled by the controller)
  assign one_mod = (mod_q > MOD_WIDTH'(1)) ? MOD_WIDTH'(1) : '0;
  assign mod_ext = {1'b0, mod_q};

  // One multiplier step, MSB first: r = 2r + xbit*y mod m
  always_comb begin
    dbl     = {mul_r_q, 1'b0};
    dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    sum     = dbl_red + (mul_x_q[MOD_WIDTH-1] ? {1'b0, mul_y_q} : '0);
    step_r  = (sum >= mod_ext) ? MOD_WIDTH'(sum - mod_ext) : MOD_WIDTH'(sum);
  end

  // Next values of the operand registers
  always_comb begin
    base_d  = base_q;
    acc_d   = acc_q;
    exp_d   = exp_q;
    mul_x_d = mul_x_q;
    mul_y_d = mul_y_q;
    mul_r_d = mul_r_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    if (cmd_i.load) begin
      base_d = base_value_i;
      exp_d  = exponent_value_i;
      acc_d  = one_mod;
    end
    if (cmd_i.mul_start) begin
      mul_r_d = '0;
      cnt_d   = CNT_WIDTH'(MOD_WIDTH - 1);
      unique case (cmd_i.mul_sel)
        MUL_REDUCE: begin
          mul_x_d = base_q;
          mul_y_d = one_mod;
        end
        MUL_ACC: begin
          mul_x_d = acc_q;
          mul_y_d = base_q;
        end
        MUL_SQUARE: begin
          mul_x_d = base_q;
          mul_y_d = base_q;
        end
        default: begin
          mul_x_d = base_q;
          mul_y_d = base_q;
        end
      endcase
    end
    if (cmd_i.mul_step) begin
      mul_r_d = step_r;
      mul_x_d = {mul_x_q[MOD_WIDTH-2:0], 1'b0};
      cnt_d   = cnt_q - CNT_WIDTH'(1);
    end
    if (cmd_i.wr_base) base_d = step_r;
    if (cmd_i.wr_acc)  acc_d  = step_r;
    if (cmd_i.exp_shift) exp_d = exp_q >> 1;
    if (cmd_i.finish) res_d = (mod_q == '0) ? '0 : acc_q;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    acc_q   <= acc_d;
    exp_q   <= exp_d;
    mul_x_q <= mul_x_d;
    mul_y_q <= mul_y_d;
    mul_r_q <= mul_r_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
  end

  // Modulus register and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= MOD_RESET;
      done_q <= 1'b0;
    end else begin
      if (modulus_we_i) mod_q <= modulus_wdata_i;
      done_q <= cmd_i.finish;
    end
  end

  assign sts_o.mul_last = (cnt_q == '0);
  assign sts_o.exp_zero = (exp_q == '0);
  assign sts_o.exp_bit  = exp_q[0];
  assign sts_o.mod_zero = (mod_q == '0);

  assign power_result_o = res_q;
  assign done_o         = done_q;

  // Partial product stays reduced while the multiplier runs
  a_r_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_step |-> (mul_r_q < mod_q))
    else $error("multiplier partial result not reduced");

  // Multiplicand is a residue while the multiplier runs
  a_y_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_step |-> (mul_y_q < mod_q))
    else $error("multiplicand not reduced");

endmodule

`default_nettype wire

// File: rtl/mexp_controller.sv
// Controller: sequences base reduction, conditional multiplies and squarings per exponent bit.
`default_nettype none

module mexp_controller
  import mexp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_REDUCE;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = sts_i.mod_zero ? ST_DONE : ST_RED_LD;
        end
      end
      ST_RED_LD: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_REDUCE;
        state_d = ST_RED_RUN;
      end
      ST_RED_RUN: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.wr_base = 1'b1;
          state_d = ST_BIT_CHK;
        end
      end
      ST_BIT_CHK: begin
        if (sts_i.exp_zero) begin
          state_d = ST_DONE;
        end else if (sts_i.exp_bit) begin
          state_d = ST_ACC_LD;
        end else begin
          state_d = ST_SQ_LD;
        end
      end
      ST_ACC_LD: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_ACC;
        state_d = ST_ACC_RUN;
      end
      ST_ACC_RUN: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.wr_acc = 1'b1;
          state_d = ST_SQ_LD;
        end
      end
      ST_SQ_LD: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_SQUARE;
        state_d = ST_SQ_RUN;
      end
      ST_SQ_RUN: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.wr_base   = 1'b1;
          cmd_o.exp_shift = 1'b1;
          state_d = ST_BIT_CHK;
        end
      end
      ST_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // The finish state is entered only from the bit check or idle
  a_done_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> ($past(state_q) == ST_BIT_CHK || $past(state_q) == ST_IDLE))
    else $error("finish reached from an unexpected state");

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation_unit.sv
// Top level: modular exponentiation by right-to-left square and multiply.
// Each modular multiply is bit-serial: a load state plus 31 steps.
// A new item is taken only while idle; busy is high while an item is in work;
// a zero modulus skips the multiplies and answers zero.
// The result is valid for one cycle with done_o and cannot be stalled by the receiver.
// Reset (rst_ni, asynchronous, active low) idles the block and sets the modulus to 1000000007.
`default_nettype none

module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [MOD_WIDTH-1:0] base_value_i,
  input  wire logic [EXP_WIDTH-1:0] exponent_value_i,
  input  wire logic                 modulus_we_i,
  input  wire logic [MOD_WIDTH-1:0] modulus_wdata_i,
  output logic [MOD_WIDTH-1:0]      power_result_o,
  output logic                      done_o
);

  cmd_t cmd;
  sts_t sts;

  mexp_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  mexp_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .base_value_i     (base_value_i),
    .exponent_value_i (exponent_value_i),
    .modulus_we_i     (modulus_we_i),
    .modulus_wdata_i  (modulus_wdata_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .power_result_o   (power_result_o),
    .done_o           (done_o)
  );

  // An accepted item makes the block busy
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // Results come one at a time, never in consecutive cycles
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

// File: tb/sv/modular_exponentiation_unit_tb.sv
// Testbench for the modular exponentiation unit: directed table, then random items per modulus.
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb
  import mexp_pkg::*;
;

  localparam logic [MOD_WIDTH-1:0] MOD_MAX = {MOD_WIDTH{1'b1}};
  localparam logic [EXP_WIDTH-1:0] EXP_MAX = {EXP_WIDTH{1'b1}};
  localparam int NUM_ROWS = 20;
  localparam int SETTINGS_PER_PHASE = 3;
  localparam int ITEMS_PER_SETTING = 23;

  // One directed item; set_mod writes the modulus first, known carries a typed answer
  typedef struct packed {
    logic                 set_mod;
    logic [MOD_WIDTH-1:0] modulus;
    logic [MOD_WIDTH-1:0] base;
    logic [EXP_WIDTH-1:0] exponent;
    logic                 known;
    logic [MOD_WIDTH-1:0] power;
  } row_t;

  localparam row_t DIR_ROWS [NUM_ROWS] = '{
    // modulus after reset: zero exponent, small powers, extremes of both fields
    '{1'b0, MOD_RESET, 0,         0,                1'b1, 1},
    '{1'b0, MOD_RESET, MOD_MAX,   0,                1'b1, 1},
    '{1'b0, MOD_RESET, 5,         1,                1'b1, 5},
    '{1'b0, MOD_RESET, 2,         10,               1'b1, 1024},
    '{1'b0, MOD_RESET, MOD_MAX,   1,                1'b0, 0},
    '{1'b0, MOD_RESET, 0,         EXP_MAX,          1'b1, 0},
    '{1'b0, MOD_RESET, 1,         EXP_MAX,          1'b1, 1},
    '{1'b0, MOD_RESET, MOD_MAX,   EXP_MAX,          1'b0, 0},
    '{1'b0, MOD_RESET, MOD_RESET, 3,                1'b1, 0},
    '{1'b0, MOD_RESET, 3,         40'd1000000006,   1'b1, 1},
    // largest modulus
    '{1'b1, MOD_MAX,   MOD_MAX,   5,                1'b1, 0},
    '{1'b1, MOD_MAX,   MOD_MAX-1, 2,                1'b1, 1},
    '{1'b0, MOD_MAX,   12345,     EXP_MAX,          1'b0, 0},
    // smallest legal modulus
    '{1'b1, 2,         3,         7,                1'b1, 1},
    '{1'b0, 2,         2,         1,                1'b1, 0},
    '{1'b0, 2,         MOD_MAX,   EXP_MAX,          1'b1, 1},
    // modulus of one: everything is zero, zero exponent too
    '{1'b1, 1,         5,         0,                1'b1, 0},
    '{1'b0, 1,         MOD_MAX,   EXP_MAX,          1'b1, 0},
    // modulus of zero: answer is zero
    '{1'b1, 0,         7,         3,                1'b1, 0},
    '{1'b0, 0,         0,         0,                1'b1, 0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [MOD_WIDTH-1:0] base_value_i;
  logic [EXP_WIDTH-1:0] exponent_value_i;
  logic                 modulus_we_i;
  logic [MOD_WIDTH-1:0] modulus_wdata_i;
  logic [MOD_WIDTH-1:0] power_result_o;
  logic                 done_o;

  logic [MOD_WIDTH-1:0] pending_powers [$];
  logic [MOD_WIDTH-1:0] want_power;
  logic [MOD_WIDTH-1:0] cur_modulus;
  int                   idle_pct;
  int                   fail_count;
  int                   items_sent;
  int                   powers_checked;
  int                   moduli_written;

  modular_exponentiation_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .base_value_i     (base_value_i),
    .exponent_value_i (exponent_value_i),
    .modulus_we_i     (modulus_we_i),
    .modulus_wdata_i  (modulus_wdata_i),
    .power_result_o   (power_result_o),
    .done_o           (done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Right-to-left square and multiply; products of two 31-bit residues fit in 64 bits
  function automatic logic [MOD_WIDTH-1:0] mod_power(input logic [MOD_WIDTH-1:0] b,
                                                     input logic [EXP_WIDTH-1:0] e,
                                                     input logic [MOD_WIDTH-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mm;
    logic [EXP_WIDTH-1:0] rest;
    if (m == '0) return '0;
    mm = 64'(m);
    acc = 64'd1 % mm;
    sq = 64'(b) % mm;
    rest = e;
    while (rest != '0) begin
      if (rest[0]) acc = (acc * sq) % mm;
      rest = rest >> 1;
      sq = (sq * sq) % mm;
    end
    return acc[MOD_WIDTH-1:0];
  endfunction

  // Present one item after an optional gap; hold start until the block takes it
  task automatic send_item(input logic [MOD_WIDTH-1:0] b, input logic [EXP_WIDTH-1:0] e,
                           input logic known, input logic [MOD_WIDTH-1:0] typed);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      // mostly short gaps, sometimes long enough to land deep inside the previous item
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2800) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    base_value_i <= b;
    exponent_value_i <= e;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_powers.push_back(known ? typed : mod_power(b, e, cur_modulus));
    items_sent++;
  endtask

  // Drop start and wait for the block to go quiet before touching the modulus
  task automatic write_modulus(input logic [MOD_WIDTH-1:0] m);
    start <= 1'b0;
    while (pending_powers.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    modulus_we_i <= 1'b1;
    modulus_wdata_i <= m;
    cur_modulus = m;
    moduli_written++;
    @(posedge clk_i);
    modulus_we_i <= 1'b0;
  endtask

  // Result checker: each strobe pops the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_powers.size() == 0) begin
        $error("power_result: expected none, actual %0d", power_result_o);
        fail_count++;
      end else begin
        want_power = pending_powers.pop_front();
        powers_checked++;
        if (power_result_o !== want_power) begin
          $error("power_result: expected %0d, actual %0d", want_power, power_result_o);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [MOD_WIDTH-1:0] b;
    logic [EXP_WIDTH-1:0] e;
    logic [MOD_WIDTH-1:0] m;
    fail_count = 0;
    items_sent = 0;
    powers_checked = 0;
    moduli_written = 0;
    idle_pct = 17;
    cur_modulus = MOD_RESET;
    rst_ni <= 1'b0;
    start <= 1'b0;
    base_value_i <= '0;
    exponent_value_i <= '0;
    modulus_we_i <= 1'b0;
    modulus_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIR_ROWS[i].set_mod) write_modulus(DIR_ROWS[i].modulus);
      send_item(DIR_ROWS[i].base, DIR_ROWS[i].exponent, DIR_ROWS[i].known, DIR_ROWS[i].power);
    end

    // random: sender idles 17%, then 71%, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 71 : 0;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        case ($urandom_range(0, 9))
          0: m = MOD_WIDTH'(2);
          1: m = MOD_MAX;
          2: m = MOD_RESET;
          3: m = MOD_WIDTH'($urandom_range(3, 1000));
          4: m = MOD_WIDTH'($urandom_range(0, 1));
          default: m = MOD_WIDTH'($urandom);
        endcase
        write_modulus(m);
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          case ($urandom_range(0, 7))
            0: b = MOD_WIDTH'($urandom_range(0, 3));
            1: b = cur_modulus - 1'b1;
            2: b = cur_modulus;
            3: b = MOD_MAX - MOD_WIDTH'($urandom_range(0, 3));
            default: b = MOD_WIDTH'($urandom);
          endcase
          case ($urandom_range(0, 7))
            0: e = EXP_WIDTH'($urandom_range(0, 3));
            1: e = EXP_WIDTH'($urandom_range(0, 255));
            2: e = EXP_MAX;
            3, 4: e = EXP_WIDTH'({$urandom, $urandom}) >> $urandom_range(0, EXP_WIDTH - 1);
            default: e = EXP_WIDTH'({$urandom, $urandom});
          endcase
          send_item(b, e, 1'b0, '0);
        end
      end
    end

    // drain, then watch a while for stray strobes
    start <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d items (%0d from the table) across %0d modulus writes", items_sent,
             NUM_ROWS, moduli_written);
    $display("Checked %0d power results, %0d mismatches", powers_checked, fail_count);
    if (fail_count == 0 && pending_powers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
